/* rtl/deo_pkg.sv */
// Shared constants, types and helper functions for the dual encoder odometry block.
package deo_pkg;

    localparam int COUNT_W   = 16;
    localparam int TOTAL_W   = 32;
    localparam int STEP_L_W  = 16;
    localparam int STEP_R_W  = 17;
    localparam int CFG_W     = 32;
    localparam int UM_W      = 32;
    localparam int MM_W      = 23;
    localparam int SPEED_W   = 49;
    localparam int TURN_W    = 50;
    localparam int UMQ_W     = 48;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 360;
    localparam int ADDR_W    = 4;

    // ceil(2^38 / 1000): exact floor division by 1000 for any 32-bit magnitude
    localparam int MM_SHIFT = 38;
    localparam int RECIP_W  = 29;
    localparam logic [RECIP_W-1:0] MM_RECIP = 29'h1062_4DD3;
    localparam int MM_PROD_W = UM_W + RECIP_W;

    localparam logic [UMQ_W-1:0] NEG_LIMIT = 48'h0000_8000_0000;
    localparam logic [UMQ_W-1:0] POS_LIMIT = 48'h0000_7FFF_FFFF;
    localparam logic [UM_W-1:0]  UM_MIN    = 32'h8000_0000;
    localparam logic [UM_W-1:0]  UM_MAX    = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        REG_UM_SCALE    = 2'd0,
        REG_SPEED_SCALE = 2'd1,
        REG_TURN_SCALE  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [UM_W-1:0] um;
        logic [UM_W-1:0] mag;
    } um_sat_t;

    // Shortest wrap-aware change; the half-range tie resolves to the positive side.
    function automatic logic [STEP_R_W-1:0] shortest_change(
        input logic [COUNT_W-1:0] now_cnt,
        input logic [COUNT_W-1:0] prev_cnt
    );
        logic [COUNT_W-1:0] d;
        begin
            d = now_cnt - prev_cnt;
            shortest_change = {d[COUNT_W-1] & (|d[COUNT_W-2:0]), d};
        end
    endfunction

    // Apply sign to a scaled magnitude and clamp to the signed 32-bit range.
    function automatic um_sat_t saturate_um(
        input logic              neg,
        input logic [UMQ_W-1:0]  q
    );
        um_sat_t r;
        begin
            if (neg)
            begin
                if (q > NEG_LIMIT)
                begin
                    r.um  = UM_MIN;
                    r.mag = UM_MIN;
                end
                else
                begin
                    r.mag = q[UM_W-1:0];
                    r.um  = UM_W'(0) - q[UM_W-1:0];
                end
            end
            else
            begin
                if (q > POS_LIMIT)
                begin
                    r.um  = UM_MAX;
                    r.mag = UM_MAX;
                end
                else
                begin
                    r.um  = q[UM_W-1:0];
                    r.mag = q[UM_W-1:0];
                end
            end
            saturate_um = r;
        end
    endfunction

    // Signed millimeters from a saturated micrometer value and its magnitude.
    function automatic logic [MM_W-1:0] um_to_mm(
        input logic             neg,
        input logic [UM_W-1:0]  mag
    );
        logic [MM_PROD_W-1:0] prod;
        logic [MM_W-1:0]      q;
        begin
            prod = MM_PROD_W'(mag) * MM_PROD_W'(MM_RECIP);
            q    = prod[MM_SHIFT +: MM_W];
            um_to_mm = neg ? (MM_W'(0) - q) : q;
        end
    endfunction

endpackage

/* rtl/dual_encoder_odometry.sv */
// Two-wheel encoder odometry: wrap-aware steps, running totals, distance, speed and turn outputs.
//
// One request (left and right raw counts) is taken per clock unless the output stalls, and the
// block keeps taking requests while earlier ones are in flight. The pipeline is stage 1 (steps
// and totals, which also updates the stored counts and totals), stage 2 (the distance, speed
// and turn multipliers), stage 3 (sign and saturation of the micrometer distance) and the
// output register, where the millimeter value comes from a reciprocal multiply; those two
// dependent multiplies set the depth. Scale registers sit on an APB port at byte addresses
// 0, 4 and 8; the user must change them only while no request is in flight, and the block
// does not enforce this.
module dual_encoder_odometry (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [deo_pkg::ADDR_W-1:0]        paddr,
    input  logic [deo_pkg::CFG_W-1:0]         pwdata,
    output logic [deo_pkg::CFG_W-1:0]         prdata,
    output logic                              pready,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] left_count, [31:16] right_count
    input  logic [deo_pkg::IN_DATA_W-1:0]     s_tdata,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] left_step, [32:16] right_step, [64:33] left_total, [96:65] right_total,
    // [128:97] left_um, [160:129] right_um, [183:161] left_mm, [206:184] right_mm,
    // [255:207] left speed Q32.16, [304:256] right speed Q32.16, [354:305] turn_rate_q16,
    // [359:355] zero
    output logic [deo_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // ---------------- configuration ----------------
    logic [deo_pkg::CFG_W-1:0] um_scale_reg;
    logic [deo_pkg::CFG_W-1:0] speed_scale_reg;
    logic [deo_pkg::CFG_W-1:0] turn_scale_reg;
    deo_pkg::reg_idx_t         cfg_idx;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = deo_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            um_scale_reg    <= '0;
            speed_scale_reg <= '0;
            turn_scale_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                deo_pkg::REG_UM_SCALE:    um_scale_reg    <= pwdata;
                deo_pkg::REG_SPEED_SCALE: speed_scale_reg <= pwdata;
                deo_pkg::REG_TURN_SCALE:  turn_scale_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            deo_pkg::REG_UM_SCALE:    prdata = um_scale_reg;
            deo_pkg::REG_SPEED_SCALE: prdata = speed_scale_reg;
            deo_pkg::REG_TURN_SCALE:  prdata = turn_scale_reg;
            default:                  prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdyo;
    logic accept;

    assign rdyo     = !vo_reg || m_tready;
    assign rdy3     = !v3_reg || rdyo;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdyo)
                vo_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: steps and running totals ----------------
    logic [deo_pkg::COUNT_W-1:0]  prev_left_reg, prev_right_reg;
    logic [deo_pkg::TOTAL_W-1:0]  left_total_reg, right_total_reg;
    logic [deo_pkg::STEP_R_W-1:0] left_chg, right_step_next;
    logic [deo_pkg::STEP_L_W-1:0] left_step_next;
    logic [deo_pkg::TOTAL_W-1:0]  left_total_next, right_total_next;

    assign left_chg         = deo_pkg::shortest_change(s_tdata[15:0], prev_left_reg);
    assign right_step_next  = deo_pkg::shortest_change(s_tdata[31:16], prev_right_reg);
    // negate the left change; the result always fits the narrower field
    assign left_step_next   = deo_pkg::STEP_L_W'(deo_pkg::STEP_R_W'(0) - left_chg);
    assign left_total_next  = left_total_reg
                            + {{(deo_pkg::TOTAL_W-deo_pkg::STEP_L_W){left_step_next[15]}},
                               left_step_next};
    assign right_total_next = right_total_reg
                            + {{(deo_pkg::TOTAL_W-deo_pkg::STEP_R_W){right_step_next[16]}},
                               right_step_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg   <= '0;
            prev_right_reg  <= '0;
            left_total_reg  <= '0;
            right_total_reg <= '0;
        end
        else if (accept)
        begin
            prev_left_reg   <= s_tdata[15:0];
            prev_right_reg  <= s_tdata[31:16];
            left_total_reg  <= left_total_next;
            right_total_reg <= right_total_next;
        end
    end

    logic [deo_pkg::STEP_L_W-1:0] ls1_reg;
    logic [deo_pkg::STEP_R_W-1:0] rs1_reg;
    logic [deo_pkg::TOTAL_W-1:0]  lt1_reg, rt1_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ls1_reg <= left_step_next;
            rs1_reg <= right_step_next;
            lt1_reg <= left_total_next;
            rt1_reg <= right_total_next;
        end
    end

    // ---------------- stage 2: multipliers ----------------
    logic [deo_pkg::TOTAL_W-1:0]   lmag, rmag;
    logic [2*deo_pkg::TOTAL_W-1:0] lprod, rprod;
    logic signed [deo_pkg::SPEED_W-1:0]  lspeed_next;
    logic signed [deo_pkg::SPEED_W:0]    rspeed_full;
    logic signed [deo_pkg::STEP_R_W:0]   diff;
    logic signed [deo_pkg::TURN_W:0]     turn_full;

    assign lmag  = lt1_reg[31] ? (deo_pkg::TOTAL_W'(0) - lt1_reg) : lt1_reg;
    assign rmag  = rt1_reg[31] ? (deo_pkg::TOTAL_W'(0) - rt1_reg) : rt1_reg;
    assign lprod = {32'd0, lmag} * {32'd0, um_scale_reg};
    assign rprod = {32'd0, rmag} * {32'd0, um_scale_reg};

    assign lspeed_next = $signed(ls1_reg) * $signed({1'b0, speed_scale_reg});
    assign rspeed_full = $signed(rs1_reg) * $signed({1'b0, speed_scale_reg});
    assign diff        = $signed({ls1_reg[15], ls1_reg[15], ls1_reg})
                       - $signed({rs1_reg[16], rs1_reg});
    assign turn_full   = diff * $signed({1'b0, turn_scale_reg});

    logic [deo_pkg::UMQ_W-1:0]    lq2_reg, rq2_reg;
    logic                         lneg2_reg, rneg2_reg;
    logic [deo_pkg::STEP_L_W-1:0] ls2_reg;
    logic [deo_pkg::STEP_R_W-1:0] rs2_reg;
    logic [deo_pkg::TOTAL_W-1:0]  lt2_reg, rt2_reg;
    logic [deo_pkg::SPEED_W-1:0]  lsp2_reg, rsp2_reg;
    logic [deo_pkg::TURN_W-1:0]   turn2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            lq2_reg   <= lprod[63:16];
            rq2_reg   <= rprod[63:16];
            lneg2_reg <= lt1_reg[31];
            rneg2_reg <= rt1_reg[31];
            ls2_reg   <= ls1_reg;
            rs2_reg   <= rs1_reg;
            lt2_reg   <= lt1_reg;
            rt2_reg   <= rt1_reg;
            lsp2_reg  <= lspeed_next;
            rsp2_reg  <= rspeed_full[deo_pkg::SPEED_W-1:0];
            turn2_reg <= turn_full[deo_pkg::TURN_W-1:0];
        end
    end

    // ---------------- stage 3: sign and saturate micrometers ----------------
    deo_pkg::um_sat_t lsat_next, rsat_next;

    assign lsat_next = deo_pkg::saturate_um(lneg2_reg, lq2_reg);
    assign rsat_next = deo_pkg::saturate_um(rneg2_reg, rq2_reg);

    deo_pkg::um_sat_t             lsat3_reg, rsat3_reg;
    logic [deo_pkg::STEP_L_W-1:0] ls3_reg;
    logic [deo_pkg::STEP_R_W-1:0] rs3_reg;
    logic [deo_pkg::TOTAL_W-1:0]  lt3_reg, rt3_reg;
    logic [deo_pkg::SPEED_W-1:0]  lsp3_reg, rsp3_reg;
    logic [deo_pkg::TURN_W-1:0]   turn3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            lsat3_reg <= lsat_next;
            rsat3_reg <= rsat_next;
            ls3_reg   <= ls2_reg;
            rs3_reg   <= rs2_reg;
            lt3_reg   <= lt2_reg;
            rt3_reg   <= rt2_reg;
            lsp3_reg  <= lsp2_reg;
            rsp3_reg  <= rsp2_reg;
            turn3_reg <= turn2_reg;
        end
    end

    // ---------------- output register: millimeters ----------------
    logic [deo_pkg::MM_W-1:0] lmm_next, rmm_next;

    assign lmm_next = deo_pkg::um_to_mm(lsat3_reg.um[31], lsat3_reg.mag);
    assign rmm_next = deo_pkg::um_to_mm(rsat3_reg.um[31], rsat3_reg.mag);

    logic [deo_pkg::STEP_L_W-1:0] lso_reg;
    logic [deo_pkg::STEP_R_W-1:0] rso_reg;
    logic [deo_pkg::TOTAL_W-1:0]  lto_reg, rto_reg;
    logic [deo_pkg::UM_W-1:0]     lumo_reg, rumo_reg;
    logic [deo_pkg::MM_W-1:0]     lmmo_reg, rmmo_reg;
    logic [deo_pkg::SPEED_W-1:0]  lspo_reg, rspo_reg;
    logic [deo_pkg::TURN_W-1:0]   turno_reg;

    always_ff @(posedge clk)
    begin
        if (rdyo && v3_reg)
        begin
            lso_reg   <= ls3_reg;
            rso_reg   <= rs3_reg;
            lto_reg   <= lt3_reg;
            rto_reg   <= rt3_reg;
            lumo_reg  <= lsat3_reg.um;
            rumo_reg  <= rsat3_reg.um;
            lmmo_reg  <= lmm_next;
            rmmo_reg  <= rmm_next;
            lspo_reg  <= lsp3_reg;
            rspo_reg  <= rsp3_reg;
            turno_reg <= turn3_reg;
        end
    end

    assign m_tdata = {5'd0, turno_reg, rspo_reg, lspo_reg, rmmo_reg, lmmo_reg,
                      rumo_reg, lumo_reg, rto_reg, lto_reg, rso_reg, lso_reg};

    // ---------------- assertions ----------------
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    a_prev_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (prev_left_reg == $past(s_tdata[15:0]))
                   && (prev_right_reg == $past(s_tdata[31:16])))
        else $error("stored counts not updated on accepted request");

    a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(left_total_reg) && $stable(right_total_reg))
        else $error("totals changed without an accepted request");

endmodule

/* test/dual_encoder_odometry_test.sv */
// Self-checking testbench for dual_encoder_odometry against a local odometry predictor.
module dual_encoder_odometry_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int PRESSURE_CYCLES = 300;
    localparam int RANDOM_PHASES   = 7;
    localparam int PHASE_ITEMS     = 100;
    localparam int MAX_REPORTS     = 10;

    localparam logic [deo_pkg::ADDR_W-1:0] UNUSED_ADDR = 4'hC;
    localparam logic [deo_pkg::CFG_W-1:0]  SCALE_MAX   = 32'hFFFF_FFFF;
    localparam logic [deo_pkg::CFG_W-1:0]  SCALE_ONE   = 32'h0001_0000;
    localparam logic [deo_pkg::CFG_W-1:0]  SCALE_HALF_RANGE = 32'h8000_0000;

    // counts that walk through ties, +-1 wraps and the largest steps both ways
    localparam logic [deo_pkg::COUNT_W-1:0] DIRECTED_COUNTS [10] = '{
        16'h0000, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000,
        16'h7FFF, 16'hFFFF, 16'h7FFE, 16'hFFFF, 16'h8000
    };

    // m_tdata fields, highest first
    typedef struct packed {
        logic [deo_pkg::TURN_W-1:0]   turn_rate;
        logic [deo_pkg::SPEED_W-1:0]  rspeed;
        logic [deo_pkg::SPEED_W-1:0]  lspeed;
        logic [deo_pkg::MM_W-1:0]     right_mm;
        logic [deo_pkg::MM_W-1:0]     left_mm;
        logic [deo_pkg::UM_W-1:0]     right_um;
        logic [deo_pkg::UM_W-1:0]     left_um;
        logic [deo_pkg::TOTAL_W-1:0]  right_total;
        logic [deo_pkg::TOTAL_W-1:0]  left_total;
        logic [deo_pkg::STEP_R_W-1:0] right_step;
        logic [deo_pkg::STEP_L_W-1:0] left_step;
    } odo_result_t;

    localparam int RESULT_W = $bits(odo_result_t);

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [deo_pkg::ADDR_W-1:0]     paddr;
    logic [deo_pkg::CFG_W-1:0]      pwdata;
    logic [deo_pkg::CFG_W-1:0]      prdata;
    logic                           pready;
    logic                           s_tvalid;
    logic                           s_tready;
    // [15:0] left_count, [31:16] right_count
    logic [deo_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    // [15:0] left_step ... [354:305] turn_rate_q16, [359:355] zero
    logic [deo_pkg::OUT_DATA_W-1:0] m_tdata;

    // predictor state and its copy of the scale registers
    logic [deo_pkg::COUNT_W-1:0] prev_left;
    logic [deo_pkg::COUNT_W-1:0] prev_right;
    logic [deo_pkg::TOTAL_W-1:0] left_sum;
    logic [deo_pkg::TOTAL_W-1:0] right_sum;
    logic [deo_pkg::CFG_W-1:0]   um_scale;
    logic [deo_pkg::CFG_W-1:0]   speed_scale;
    logic [deo_pkg::CFG_W-1:0]   turn_scale;

    odo_result_t                 pending_results[$];
    int                          mismatches;
    int                          cycle_count;
    logic [deo_pkg::COUNT_W-1:0] last_left;
    logic [deo_pkg::COUNT_W-1:0] last_right;
    bit                          tx_idle_on;
    bit                          rx_idle_on;
    bit                          hold_request;

    dual_encoder_odometry u_top (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Shortest signed change, half-range tie goes positive.
    function automatic longint wheel_step(logic [deo_pkg::COUNT_W-1:0] now_cnt,
                                          logic [deo_pkg::COUNT_W-1:0] prev_cnt);
        logic [deo_pkg::COUNT_W-1:0] d;
        d = now_cnt - prev_cnt;
        if (d > 16'h8000)
            return longint'(d) - 65536;
        return longint'(d);
    endfunction

    // total * scale / 2^16 toward zero, clamped to signed 32 bits
    function automatic longint scaled_um(longint total, logic [deo_pkg::CFG_W-1:0] scale);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (total < 0) ? 64'(-total) : 64'(total);
        q   = (mag * {32'b0, scale}) >> 16;
        if (total < 0)
            return (q > 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(q);
        return (q > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(q);
    endfunction

    function automatic odo_result_t predict_odometry(logic [deo_pkg::COUNT_W-1:0] lc,
                                                     logic [deo_pkg::COUNT_W-1:0] rc);
        longint      ls;
        longint      rs;
        longint      lum;
        longint      rum;
        odo_result_t e;
        ls = -wheel_step(lc, prev_left);
        rs = wheel_step(rc, prev_right);
        left_sum   = left_sum + 32'(ls);
        right_sum  = right_sum + 32'(rs);
        prev_left  = lc;
        prev_right = rc;
        lum = scaled_um(longint'($signed(left_sum)), um_scale);
        rum = scaled_um(longint'($signed(right_sum)), um_scale);
        e.left_step   = 16'(ls);
        e.right_step  = 17'(rs);
        e.left_total  = left_sum;
        e.right_total = right_sum;
        e.left_um     = 32'(lum);
        e.right_um    = 32'(rum);
        e.left_mm     = 23'(lum / 1000);
        e.right_mm    = 23'(rum / 1000);
        e.lspeed      = 49'(ls * longint'({32'b0, speed_scale}));
        e.rspeed      = 49'(rs * longint'({32'b0, speed_scale}));
        e.turn_rate   = 50'((ls - rs) * longint'({32'b0, turn_scale}));
        return e;
    endfunction

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0s: expected %h, got %h", field, want, got);
        end
    endtask

    // Check results, track register writes and predict each accepted request, in that order.
    always @(posedge clk)
    begin
        odo_result_t got;
        odo_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = odo_result_t'(m_tdata[RESULT_W-1:0]);
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result with no request pending: %h", m_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("left_step", want.left_step, got.left_step);
                    check_field("right_step", want.right_step, got.right_step);
                    check_field("left_total", want.left_total, got.left_total);
                    check_field("right_total", want.right_total, got.right_total);
                    check_field("left_um", want.left_um, got.left_um);
                    check_field("right_um", want.right_um, got.right_um);
                    check_field("left_mm", want.left_mm, got.left_mm);
                    check_field("right_mm", want.right_mm, got.right_mm);
                    check_field("lspeed", want.lspeed, got.lspeed);
                    check_field("rspeed", want.rspeed, got.rspeed);
                    check_field("turn_rate_q16", want.turn_rate, got.turn_rate);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    deo_pkg::REG_UM_SCALE:    um_scale = pwdata;
                    deo_pkg::REG_SPEED_SCALE: speed_scale = pwdata;
                    deo_pkg::REG_TURN_SCALE:  turn_scale = pwdata;
                    default:                  ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_odometry(s_tdata[15:0], s_tdata[31:16]));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dual_encoder_odometry_test: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold when requested.
    initial
    begin
        int wait_left;
        int g;
        wait_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (wait_left > 0)
            begin
                m_tready <= 1'b0;
                wait_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                wait_left = PRESSURE_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                g = rx_idle_on ? random_gap() : 0;
                if (g > 0)
                begin
                    wait_left = g - 1;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [deo_pkg::ADDR_W-1:0] reg_addr(deo_pkg::reg_idx_t idx);
        return {idx, 2'b00};
    endfunction

    function automatic logic [deo_pkg::CFG_W-1:0] random_scale();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SCALE_MAX;
            2:       return SCALE_ONE;
            3:       return $urandom_range(0, 32'hFFFF);
            default: return $urandom();
        endcase
    endfunction

    // Mostly small moves, with ties, near-ties and jumps mixed in.
    function automatic logic [deo_pkg::COUNT_W-1:0] next_count(
        logic [deo_pkg::COUNT_W-1:0] last);
        int                          pick;
        logic [deo_pkg::COUNT_W-1:0] jitter;
        pick   = $urandom_range(0, 99);
        jitter = 16'($urandom_range(0, 64)) - 16'd32;
        if (pick < 60)
            return last + jitter;
        if (pick < 70)
            return last + 16'h8000;
        if (pick < 80)
            return last + 16'h8000 + (jitter[0] ? 16'h0001 : 16'hFFFF);
        if (pick < 92)
            return 16'($urandom());
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            default: return 16'h8000;
        endcase
    endfunction

    task automatic write_reg(logic [deo_pkg::ADDR_W-1:0] addr,
                             logic [deo_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // leave the bus idle before the next setup phase
        @(negedge clk);
    endtask

    // Drop the request line and let the pipeline empty out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_scales(logic [deo_pkg::CFG_W-1:0] um, logic [deo_pkg::CFG_W-1:0] speed,
                              logic [deo_pkg::CFG_W-1:0] turn);
        wait_idle();
        write_reg(reg_addr(deo_pkg::REG_UM_SCALE), um);
        write_reg(reg_addr(deo_pkg::REG_SPEED_SCALE), speed);
        write_reg(reg_addr(deo_pkg::REG_TURN_SCALE), turn);
    endtask

    task automatic send_counts(logic [deo_pkg::COUNT_W-1:0] lc, logic [deo_pkg::COUNT_W-1:0] rc);
        int gap;
        gap = tx_idle_on ? random_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {rc, lc};
        last_left  = lc;
        last_right = rc;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_counts(int count);
        repeat (count)
            send_counts(next_count(last_left), next_count(last_right));
    endtask

    // All scales still at their reset value of zero.
    task automatic test_zero_scales_after_reset();
        send_counts(16'h0000, 16'h0000);
        send_counts(16'hFFFF, 16'h0001);
        send_counts(16'h0000, 16'h0000);
    endtask

    // Largest scales: distances saturate both ways, speeds and turn rate hit their extremes.
    task automatic test_directed_extremes();
        set_scales(SCALE_MAX, SCALE_MAX, SCALE_MAX);
        write_reg(UNUSED_ADDR, $urandom());
        foreach (DIRECTED_COUNTS[i])
            send_counts(DIRECTED_COUNTS[i], DIRECTED_COUNTS[i]);
    endtask

    task automatic test_half_range_scale();
        set_scales(SCALE_HALF_RANGE, 32'd1, SCALE_ONE);
        send_counts(16'h0000, 16'h0000);
        send_counts(16'h8000, 16'h8000);
        send_counts(16'h0000, 16'h0001);
        send_counts(16'h0001, 16'h8000);
    endtask

    // Hold off the result side while requests keep coming, so the input stalls.
    task automatic test_output_backpressure();
        set_scales(random_scale(), random_scale(), random_scale());
        tx_idle_on   = 1'b0;
        hold_request = 1'b1;
        send_random_counts(60);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_scales(random_scale(), random_scale(), random_scale());
            tx_idle_on = (phase != 2) && (phase != 4);
            rx_idle_on = (phase != 3) && (phase != 4);
            send_random_counts(PHASE_ITEMS);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        prev_left    = '0;
        prev_right   = '0;
        left_sum     = '0;
        right_sum    = '0;
        um_scale     = '0;
        speed_scale  = '0;
        turn_scale   = '0;
        mismatches   = 0;
        cycle_count  = 0;
        last_left    = '0;
        last_right   = '0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_request = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_scales_after_reset();
        test_directed_extremes();
        test_half_range_scale();
        test_output_backpressure();
        test_random_phases();

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("dual_encoder_odometry_test: done, clean");
        else
            $display("dual_encoder_odometry_test: done, errors");
        $finish;
    end

endmodule
